// ===== sv/hcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcm_pkg: shared types and constants of the heat-map color mapper
// Opcodes, payload structs and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package hcm_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    localparam logic [2:0] REG_FIXED_LIMITS = 3'd0;
    localparam logic [2:0] REG_LOG_SCALE    = 3'd1;
    localparam logic [2:0] REG_CENTER_ZERO  = 3'd2;
    localparam logic [2:0] REG_LIMIT_LOW    = 3'd3;
    localparam logic [2:0] REG_LIMIT_HIGH   = 3'd4;

    // Significant bits of the sample field; the rest is sign extension.
    localparam int SAMPLE_BITS = 32;
    localparam int LOG_FRAC = 8;
    localparam logic [7:0] GRAY = 8'd127;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // empty the running limits
        logic scan;      // fold the held sample into the limits
        logic prep;      // first map step: limits and special cases
        logic logs;      // compute Mitchell logs
        logic setup;     // form numerator and denominator
        logic div_step;  // one quotient bit
        logic finish;    // ramp and write result
    } dp_cmd_t;

    typedef struct packed {
        logic special;   // special case found, result already formed
        logic logm;      // log path needed
    } dp_sts_t;

endpackage

// ===== sv/hcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcm_ctrl: sequencer of the heat-map color mapper
// Steps one item at a time through decode, log, setup, division and output.
// ----------------------------------------------------------------------------
module hcm_ctrl #(
    parameter int FRACTION_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic [1:0]        in_opcode,
    input  logic              out_free,
    input  hcm_pkg::dp_sts_t  sts,
    output hcm_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              res_load
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_LOGS  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    // The scan command acts in the cycle after acceptance, on the held sample.
    logic          scan_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        res_load   = 1'b0;
        cmd.scan   = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd.clear = (in_opcode == hcm_pkg::OP_CLEAR);
                    if (in_opcode == hcm_pkg::OP_MAP)
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = S_LOGS;
            end
            S_LOGS:
            begin
                if (sts.special)
                    state_next = S_FIN;
                else
                begin
                    cmd.logs = sts.logm;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FRACTION_BITS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            scan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= in_take && (in_opcode == hcm_pkg::OP_SCAN) && state_reg == S_IDLE;
        end
    end

    assign busy = (state_reg != S_IDLE) || scan_reg;

    // Division runs exactly FRACTION_BITS steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && state_next == S_FIN) |-> cnt_reg == CW'(FRACTION_BITS - 1))
        else $error("division step count wrong");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> state_reg == S_FIN)
        else $error("result loaded outside finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg |-> $past(state_reg) == S_IDLE)
        else $error("scan issued while busy");

endmodule

// ===== sv/hcm_dp.sv =====
// ----------------------------------------------------------------------------
// hcm_dp: datapath of the heat-map color mapper
// Running limits, Mitchell logs, bit-serial fraction division and ramp.
// ----------------------------------------------------------------------------
module hcm_dp #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcm_pkg::dp_cmd_t     cmd,
    input  logic [31:0]          sample,
    input  logic                 load,
    input  logic                 fixed_limits,
    input  logic                 log_scale,
    input  logic                 center_zero,
    input  logic signed [31:0]   limit_low,
    input  logic signed [31:0]   limit_high,
    output hcm_pkg::dp_sts_t     sts,
    output hcm_pkg::out_item_t   result
);

    localparam int FS = 1 << FRACTION_BITS;
    localparam int Q  = FS / 4;
    localparam int WW = 36;   // numerator and denominator width
    localparam int LW = 14;   // log width: 6 integer + 8 fraction bits

    logic signed [31:0] x_reg, lo_run_reg, hi_run_reg;
    logic               seen_reg;
    logic signed [31:0] x_ext;
    assign x_ext = 32'(signed'(sample[hcm_pkg::SAMPLE_BITS-1:0]));

    // Sample holder, loaded at acceptance.
    always_ff @(posedge clk)
    begin
        if (load)
            x_reg <= x_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_run_reg <= '0;
            hi_run_reg <= '0;
            seen_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            lo_run_reg <= '0;
            hi_run_reg <= '0;
            seen_reg   <= 1'b0;
        end
        else if (cmd.scan && !(log_scale && x_reg <= 0))
        begin
            if (!seen_reg || x_reg < lo_run_reg)
                lo_run_reg <= x_reg;
            if (!seen_reg || x_reg > hi_run_reg)
                hi_run_reg <= x_reg;
            seen_reg <= 1'b1;
        end
    end

    // Prep step: choose limits and resolve the special cases.
    logic signed [31:0] lo_reg, hi_reg, lo_c, hi_c;
    logic               special_reg, logm_reg;
    hcm_pkg::out_item_t spec_reg;

    always_comb
    begin
        lo_c = fixed_limits ? limit_low  : lo_run_reg;
        hi_c = fixed_limits ? limit_high : hi_run_reg;
        if (log_scale)
        begin
            if (lo_c < 1)
                lo_c = 32'sd1;
            if (hi_c < 1)
                hi_c = 32'sd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            lo_reg   <= lo_c;
            hi_reg   <= hi_c;
            logm_reg <= log_scale;
            special_reg <= 1'b1;
            if (!fixed_limits && !seen_reg)
                spec_reg <= '{hcm_pkg::GRAY, hcm_pkg::GRAY, hcm_pkg::GRAY};
            else if (lo_c == hi_c)
                spec_reg <= '{hcm_pkg::GRAY, hcm_pkg::GRAY, hcm_pkg::GRAY};
            else if ((fixed_limits || log_scale) && x_reg < lo_c)
                spec_reg <= '{8'd0, 8'd0, 8'd0};
            else if (fixed_limits && x_reg > hi_c)
                spec_reg <= '{8'd255, 8'd255, 8'd255};
            else
                special_reg <= 1'b0;
        end
    end

    assign sts.special = special_reg;
    assign sts.logm    = logm_reg;

    // Mitchell log2 of a positive 32-bit value.
    function automatic logic [LW-1:0] mlog2(input logic [31:0] v);
        logic [4:0]  k;
        logic [31:0] m;
        logic [7:0]  fr;
        k = '0;
        for (int i = 0; i < 32; i++)
            if (v[i])
                k = 5'(i);
        m = v & ~(32'd1 << k);
        if (k >= 5'd8)
            fr = 8'(m >> (k - 5'd8));
        else
            fr = 8'(m << (5'd8 - k));
        return {1'b0, k, fr};
    endfunction

    logic [LW-1:0] lx_reg, llo_reg, lhi_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.logs)
        begin
            lx_reg  <= mlog2(x_reg);
            llo_reg <= mlog2(lo_reg);
            lhi_reg <= mlog2(hi_reg);
        end
    end

    // Setup: numerator and denominator, then early saturation.
    logic signed [WW-1:0] num_c, den_c, a_c, b_c;
    always_comb
    begin
        a_c = lo_reg < 0 ? -WW'(lo_reg) : WW'(lo_reg);
        b_c = hi_reg < 0 ? -WW'(hi_reg) : WW'(hi_reg);
        if (b_c > a_c)
            a_c = b_c;
        if (logm_reg)
        begin
            num_c = WW'(signed'({1'b0, lx_reg})) - WW'(signed'({1'b0, llo_reg}));
            den_c = WW'(signed'({1'b0, lhi_reg})) - WW'(signed'({1'b0, llo_reg}));
        end
        else if (!fixed_limits && center_zero)
        begin
            num_c = WW'(x_reg) + a_c;
            den_c = a_c <<< 1;
        end
        else
        begin
            num_c = WW'(x_reg) - WW'(lo_reg);
            den_c = WW'(hi_reg) - WW'(lo_reg);
        end
    end

    logic [WW-1:0]            rem_reg, d_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic                     sat0_reg, satf_reg;
    logic [WW:0]              rem2;
    assign rem2 = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            sat0_reg <= num_c <= 0;
            satf_reg <= num_c > 0 && num_c >= den_c;
            rem_reg  <= num_c;
            d_reg    <= den_c;
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem2 >= {1'b0, d_reg})
            begin
                rem_reg <= WW'(rem2 - {1'b0, d_reg});
                q_reg   <= {q_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= WW'(rem2);
                q_reg   <= {q_reg[FRACTION_BITS-2:0], 1'b0};
            end
        end
    end

    // Ramp and segment select.
    logic [FRACTION_BITS:0] f, t;
    logic [FRACTION_BITS+10:0] prod;
    logic [7:0] rv;
    hcm_pkg::out_item_t col;
    always_comb
    begin
        if (sat0_reg)
            f = '0;
        else if (satf_reg)
            f = (FRACTION_BITS+1)'(FS);
        else
            f = {1'b0, q_reg};
        if (f < (FRACTION_BITS+1)'(Q))
            t = f;
        else if (f < (FRACTION_BITS+1)'(2*Q))
            t = (FRACTION_BITS+1)'(2*Q) - f;
        else if (f < (FRACTION_BITS+1)'(3*Q))
            t = f - (FRACTION_BITS+1)'(2*Q);
        else
            t = (FRACTION_BITS+1)'(FS) - f;
        prod = (FRACTION_BITS+11)'(t) * (FRACTION_BITS+11)'(1020)
             + (FRACTION_BITS+11)'(FS/2);
        rv = 8'(prod >> FRACTION_BITS);
        if (f < (FRACTION_BITS+1)'(Q))
            col = '{8'd0, rv, 8'd255};
        else if (f < (FRACTION_BITS+1)'(2*Q))
            col = '{8'd0, 8'd255, rv};
        else if (f < (FRACTION_BITS+1)'(3*Q))
            col = '{rv, 8'd255, 8'd0};
        else
            col = '{8'd255, rv, 8'd0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            result <= special_reg ? spec_reg : col;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg && $past(cmd.clear) |-> 1'b0 || !seen_reg)
        else $error("clear left limits valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> lo_run_reg <= hi_run_reg)
        else $error("running limits inverted");
    // Saturated fractions ignore the quotient, so their remainder is not bounded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat0_reg && !satf_reg) |-> rem_reg < d_reg)
        else $error("division remainder out of range");

endmodule

// ===== sv/heatmap_color_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// heatmap_color_mapper_unit: scalar to heat-map RGB mapper
// Tracks running limits and maps samples onto a blue to red color ramp.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | opcode, sample
// out     | output    | out_valid/out_stall | red, green, blue
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A map transaction steps through prep, logs, setup, the bit-serial quotient
// loop and the final step; special cases go from logs straight to the final step.
// Reset clears the running limits and all configuration to zero.
// The result register holds a finished color while the next item is taken;
// a stalled output holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module heatmap_color_mapper_unit #(
    parameter int FRACTION_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hcm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hcm_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic fixed_reg, log_reg, cz_reg;
    logic signed [31:0] llo_reg, lhi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_reg <= 1'b0;
            log_reg   <= 1'b0;
            cz_reg    <= 1'b0;
            llo_reg   <= '0;
            lhi_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hcm_pkg::REG_FIXED_LIMITS: fixed_reg <= cfg_data[0];
                hcm_pkg::REG_LOG_SCALE:    log_reg   <= cfg_data[0];
                hcm_pkg::REG_CENTER_ZERO:  cz_reg    <= cfg_data[0];
                hcm_pkg::REG_LIMIT_LOW:    llo_reg   <= cfg_data;
                hcm_pkg::REG_LIMIT_HIGH:   lhi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    hcm_pkg::dp_cmd_t cmd;
    hcm_pkg::dp_sts_t sts;
    logic busy, res_load, in_take, out_free, ovalid_reg;

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;
    assign out_free = !ovalid_reg || !out_stall;

    hcm_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_take(in_take), .in_opcode(in_data.opcode),
        .out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy), .res_load(res_load)
    );

    hcm_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(in_data.sample),
        .load(in_take), .fixed_limits(fixed_reg), .log_scale(log_reg),
        .center_zero(cz_reg), .limit_low(llo_reg), .limit_high(lhi_reg),
        .sts(sts), .result(out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (!out_stall)
            ovalid_reg <= 1'b0;
    end
    assign out_valid = ovalid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !res_load)
        else $error("result overwritten while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> !busy)
        else $error("item taken while busy");

endmodule
